// ===== design/lgfm_pkg.sv =====
// lgfm_pkg: shared types, codes and reset constants of the led group fade controller
// no dependencies; used by lgfm_step and led_group_fade_mode_controller

package lgfm_pkg;

    // command codes
    typedef logic [2:0] t_opcode;
    localparam t_opcode OP_TICK   = 3'd0;
    localparam t_opcode OP_TOGGLE = 3'd1;
    localparam t_opcode OP_ROLL   = 3'd2;
    localparam t_opcode OP_DIMM   = 3'd3;
    localparam t_opcode OP_ON     = 3'd4;

    // group mode
    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_ON     = 2'd1,
        MODE_TO_ON  = 2'd2,
        MODE_TO_OFF = 2'd3
    } t_mode;

    // configuration register indexes
    typedef logic [2:0] t_reg_idx;
    localparam t_reg_idx REG_FADE_IN_DELAY  = 3'd0;
    localparam t_reg_idx REG_FADE_OUT_DELAY = 3'd1;
    localparam t_reg_idx REG_FADE_IN_STEP   = 3'd2;
    localparam t_reg_idx REG_FADE_OUT_STEP  = 3'd3;
    localparam t_reg_idx REG_DIMM_COUNT     = 3'd4;
    localparam t_reg_idx REG_DIMM_TABLE     = 3'd5;
    localparam t_reg_idx REG_MASK_COUNT     = 3'd6;
    localparam t_reg_idx REG_MASK_TABLE     = 3'd7;

    localparam int CFG_DATA_W = 64;
    localparam int LED_IDX_W  = 3;

    typedef struct packed {
        logic [7:0]  fade_in_delay;
        logic [7:0]  fade_out_delay;
        logic [7:0]  fade_in_step;
        logic [7:0]  fade_out_step;
        logic [3:0]  dimm_count;
        logic [63:0] dimm_table;
        logic [3:0]  mask_count;
        logic [63:0] mask_table;
    } t_cfg;

    typedef struct packed {
        t_opcode    op;
        logic [7:0] arg;
        logic       keep;
    } t_cmd;

    localparam logic [63:0] DIMM_TABLE_RST = 64'hFF00_0000_0000_0000;
    localparam logic [63:0] MASK_TABLE_RST = 64'h0;
    localparam logic [7:0]  DELAY_RST      = 8'd1;

    localparam t_cfg CFG_RST = '{
        fade_in_delay:  DELAY_RST,
        fade_out_delay: DELAY_RST,
        fade_in_step:   DELAY_RST,
        fade_out_step:  DELAY_RST,
        dimm_count:     4'd8,
        dimm_table:     DIMM_TABLE_RST,
        mask_count:     4'd0,
        mask_table:     MASK_TABLE_RST
    };

    // byte k of a packed eight-entry table
    function automatic logic [7:0] table_byte(input logic [63:0] tbl, input logic [2:0] k);
        logic [7:0] b;
        b = tbl[8*k +: 8];
        return b;
    endfunction

endpackage

// ===== design/lgfm_step.sv =====
// lgfm_step: next-state logic for one command or tick over the whole led group
// depends on lgfm_pkg

module lgfm_step #(
    parameter int LEDS       = 4,
    parameter int DIMM_SLOTS = 8,
    parameter int MASK_SLOTS = 8
) (
    input  lgfm_pkg::t_cfg             i_cfg,
    input  lgfm_pkg::t_cmd             i_cmd,
    input  logic [LEDS-1:0][7:0]       i_level,
    input  logic [LEDS-1:0][7:0]       i_target,
    input  logic [LEDS-1:0][7:0]       i_timer,
    input  logic [LEDS-1:0][7:0]       i_on_level,
    input  logic [LEDS-1:0][2:0]       i_dimm_idx,
    input  lgfm_pkg::t_mode            i_mode,
    input  logic [2:0]                 i_mask_idx,
    input  logic [7:0]                 i_mask,
    output logic [LEDS-1:0][7:0]       o_level,
    output logic [LEDS-1:0][7:0]       o_target,
    output logic [LEDS-1:0][7:0]       o_timer,
    output logic [LEDS-1:0][7:0]       o_on_level,
    output logic [LEDS-1:0][2:0]       o_dimm_idx,
    output logic [LEDS-1:0]            o_changed,
    output lgfm_pkg::t_mode            o_mode,
    output logic [2:0]                 o_mask_idx,
    output logic [7:0]                 o_mask
);

    logic       is_tick, is_toggle, is_roll, is_dimm, is_on;
    logic [3:0] dimm_cnt, mask_cnt, mask_nx;
    logic [7:0] dimm_arg;
    logic       dimm_roll, all_zero, steady;
    logic [2:0] dimm_set;
    logic       do_dimm, do_roll, do_on, do_off, use_keep;

    assign is_tick   = (i_cmd.op == lgfm_pkg::OP_TICK);
    assign is_toggle = (i_cmd.op == lgfm_pkg::OP_TOGGLE);
    assign is_roll   = (i_cmd.op == lgfm_pkg::OP_ROLL);
    assign is_dimm   = (i_cmd.op == lgfm_pkg::OP_DIMM);
    assign is_on     = (i_cmd.op == lgfm_pkg::OP_ON);

    // effective counts
    always_comb begin
        if (i_cfg.dimm_count == 4'd0) begin
            dimm_cnt = 4'd1;
        end else if (i_cfg.dimm_count > 4'(DIMM_SLOTS)) begin
            dimm_cnt = 4'(DIMM_SLOTS);
        end else begin
            dimm_cnt = i_cfg.dimm_count;
        end
        if (i_cfg.mask_count > 4'(MASK_SLOTS)) begin
            mask_cnt = 4'(MASK_SLOTS);
        end else begin
            mask_cnt = i_cfg.mask_count;
        end
    end

    // roll dimm in on mode acts as dimm to index 0
    assign dimm_arg  = is_dimm ? i_cmd.arg : 8'd0;
    assign dimm_roll = (dimm_arg == {4'd0, dimm_cnt});
    assign dimm_set  = (dimm_arg > {4'd0, dimm_cnt}) ? 3'(dimm_cnt - 4'd1) : dimm_arg[2:0];

    always_comb begin
        all_zero = 1'b1;
        steady   = 1'b1;
        for (int i = 0; i < LEDS; i++) begin
            if (i_dimm_idx[i] != 3'd0) all_zero = 1'b0;
            if (i_target[i] != i_level[i]) steady = 1'b0;
        end
    end

    assign do_dimm  = is_dimm || (is_roll && i_mode == lgfm_pkg::MODE_ON);
    assign do_roll  = is_roll && i_mode == lgfm_pkg::MODE_OFF && mask_cnt != 4'd0;
    assign do_off   = is_toggle && i_mode == lgfm_pkg::MODE_ON;
    assign do_on    = (is_toggle && i_mode == lgfm_pkg::MODE_OFF)
                   || (is_roll && (i_mode == lgfm_pkg::MODE_ON || i_mode == lgfm_pkg::MODE_OFF))
                   || is_dimm || is_on;
    assign use_keep = !(is_on && !i_cmd.keep);

    // disable mask roll
    always_comb begin
        mask_nx = {1'b0, i_mask_idx} + 4'd1;
        if (mask_nx >= mask_cnt) mask_nx = 4'd0;
        if (do_roll) begin
            o_mask_idx = mask_nx[2:0];
            o_mask     = lgfm_pkg::table_byte(i_cfg.mask_table, mask_nx[2:0]);
        end else begin
            o_mask_idx = i_mask_idx;
            o_mask     = i_mask;
        end
    end

    // group mode
    always_comb begin
        o_mode = i_mode;
        if (is_toggle) begin
            if (i_mode == lgfm_pkg::MODE_ON) o_mode = lgfm_pkg::MODE_TO_OFF;
            else if (i_mode == lgfm_pkg::MODE_OFF) o_mode = lgfm_pkg::MODE_TO_ON;
        end else if (is_dimm || is_on) begin
            o_mode = lgfm_pkg::MODE_TO_ON;
        end else if (is_tick && steady) begin
            if (i_mode == lgfm_pkg::MODE_TO_ON) o_mode = lgfm_pkg::MODE_ON;
            else if (i_mode == lgfm_pkg::MODE_TO_OFF) o_mode = lgfm_pkg::MODE_OFF;
        end
    end

    // per led
    always_comb begin
        logic [7:0] tm_dec;
        logic [7:0] v;
        for (int i = 0; i < LEDS; i++) begin
            // dimm index and on-level
            if (!do_dimm) begin
                o_dimm_idx[i] = i_dimm_idx[i];
            end else if (dimm_roll) begin
                if (all_zero) o_dimm_idx[i] = 3'(dimm_cnt - 4'd1);
                else if (i_dimm_idx[i] == 3'd0) o_dimm_idx[i] = 3'd0;
                else o_dimm_idx[i] = i_dimm_idx[i] - 3'd1;
            end else begin
                o_dimm_idx[i] = dimm_set;
            end
            o_on_level[i] = do_dimm ? lgfm_pkg::table_byte(i_cfg.dimm_table, o_dimm_idx[i])
                                    : i_on_level[i];

            // fade step on tick
            o_level[i]   = i_level[i];
            o_target[i]  = i_target[i];
            o_timer[i]   = i_timer[i];
            o_changed[i] = 1'b0;
            tm_dec       = i_timer[i] - 8'd1;
            if (is_tick && i_target[i] != i_level[i]) begin
                if (tm_dec == 8'd0) begin
                    o_changed[i] = 1'b1;
                    if (i_target[i] > i_level[i]) begin
                        o_level[i] = i_level[i] + 8'd1;
                        o_timer[i] = i_cfg.fade_in_step;
                    end else begin
                        o_level[i] = i_level[i] - 8'd1;
                        o_timer[i] = i_cfg.fade_out_step;
                    end
                end else begin
                    o_timer[i] = tm_dec;
                end
            end

            if (do_off) begin
                o_target[i] = 8'd0;
                o_timer[i]  = i_cfg.fade_out_delay;
            end
            v = use_keep ? o_on_level[i] : i_cmd.arg;
            if (do_on) begin
                o_target[i] = o_mask[3'(i)] ? 8'd0 : v;
                o_timer[i]  = i_cfg.fade_in_delay;
            end
        end
    end

endmodule

// ===== design/led_group_fade_mode_controller.sv =====
// led_group_fade_mode_controller: top level of the led group fade and mode controller
// depends on lgfm_pkg and lgfm_step

// A group of LEDS leds shares one mode (off, on, turning on, turning off). Each request
// is a tick (opcode 0) or a command (toggle, roll dimm, dimm, on); every request updates
// the group state and is then reported as LEDS results, one per led in index order,
// with o_last set on the result for led LEDS-1. The serializer sends one led per cycle
// while i_out_stall is low; a request passes the request register, then the result
// snapshot. The request register in front of the update logic lets the next request be
// taken while the previous one is still being reported. Configuration is to be
// written by the user through i_cfg_we / i_cfg_index / i_cfg_data only while the block
// is idle, not enforced by the block; registers take the low bits of the data they need.

module led_group_fade_mode_controller #(
    parameter int LEDS       = 4,
    parameter int DIMM_SLOTS = 8,
    parameter int MASK_SLOTS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration write port
    input  logic                              i_cfg_we,
    input  lgfm_pkg::t_reg_idx                i_cfg_index,
    input  logic [lgfm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [2:0]                        i_opcode,
    input  logic [7:0]                        i_argument,
    input  logic                              i_keep_levels,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [lgfm_pkg::LED_IDX_W-1:0]    o_led_index,
    output logic [7:0]                        o_level,
    output logic [7:0]                        o_target_level,
    output logic                              o_level_changed,
    output logic [1:0]                        o_group_mode,
    output logic [7:0]                        o_disabled_leds,
    output logic                              o_last
);

    localparam int IDX_W = (LEDS > 1) ? $clog2(LEDS) : 1;
    // on-level after reset: last valid entry of the reset dimm table
    localparam logic [7:0] ON_LEVEL_RST = lgfm_pkg::DIMM_TABLE_RST[8*(DIMM_SLOTS-1) +: 8];

    // configuration registers
    lgfm_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lgfm_pkg::CFG_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                lgfm_pkg::REG_FADE_IN_DELAY:  r_cfg.fade_in_delay  <= i_cfg_data[7:0];
                lgfm_pkg::REG_FADE_OUT_DELAY: r_cfg.fade_out_delay <= i_cfg_data[7:0];
                lgfm_pkg::REG_FADE_IN_STEP:   r_cfg.fade_in_step   <= i_cfg_data[7:0];
                lgfm_pkg::REG_FADE_OUT_STEP:  r_cfg.fade_out_step  <= i_cfg_data[7:0];
                lgfm_pkg::REG_DIMM_COUNT:     r_cfg.dimm_count     <= i_cfg_data[3:0];
                lgfm_pkg::REG_DIMM_TABLE:     r_cfg.dimm_table     <= i_cfg_data;
                lgfm_pkg::REG_MASK_COUNT:     r_cfg.mask_count     <= i_cfg_data[3:0];
                lgfm_pkg::REG_MASK_TABLE:     r_cfg.mask_table     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // handshake bookkeeping
    logic r_in_valid;
    lgfm_pkg::t_cmd r_cmd;
    logic r_busy;
    logic [IDX_W-1:0] r_idx;
    logic in_take, out_take, out_done, snap_free, adv;

    assign o_out_valid = r_busy;
    assign o_last      = (r_idx == IDX_W'(LEDS - 1));
    assign out_take    = r_busy && !i_out_stall;
    assign out_done    = out_take && o_last;
    // snapshot can be reloaded when empty or when its final result leaves now
    assign snap_free   = !r_busy || out_done;
    assign adv         = r_in_valid && snap_free;
    assign o_in_stall  = r_in_valid && !adv;
    assign in_take     = i_in_valid && !o_in_stall;

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_take || (r_in_valid && !adv);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd <= '{op: i_opcode, arg: i_argument, keep: i_keep_levels};
        end
    end

    // group state
    logic [LEDS-1:0][7:0] r_level, r_target, r_timer, r_on_level;
    logic [LEDS-1:0][2:0] r_dimm_idx;
    lgfm_pkg::t_mode      r_mode;
    logic [2:0]           r_mask_idx;
    logic [7:0]           r_mask;

    logic [LEDS-1:0][7:0] n_level, n_target, n_timer, n_on_level;
    logic [LEDS-1:0][2:0] n_dimm_idx;
    logic [LEDS-1:0]      n_changed;
    lgfm_pkg::t_mode      n_mode;
    logic [2:0]           n_mask_idx;
    logic [7:0]           n_mask;

    lgfm_step #(
        .LEDS       (LEDS),
        .DIMM_SLOTS (DIMM_SLOTS),
        .MASK_SLOTS (MASK_SLOTS)
    ) u_step (
        .i_cfg      (r_cfg),
        .i_cmd      (r_cmd),
        .i_level    (r_level),
        .i_target   (r_target),
        .i_timer    (r_timer),
        .i_on_level (r_on_level),
        .i_dimm_idx (r_dimm_idx),
        .i_mode     (r_mode),
        .i_mask_idx (r_mask_idx),
        .i_mask     (r_mask),
        .o_level    (n_level),
        .o_target   (n_target),
        .o_timer    (n_timer),
        .o_on_level (n_on_level),
        .o_dimm_idx (n_dimm_idx),
        .o_changed  (n_changed),
        .o_mode     (n_mode),
        .o_mask_idx (n_mask_idx),
        .o_mask     (n_mask)
    );

    // state advances once per request, when it moves into the snapshot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEDS; i++) begin
                r_level[i]    <= 8'd0;
                r_target[i]   <= 8'd0;
                r_timer[i]    <= lgfm_pkg::DELAY_RST;
                r_on_level[i] <= ON_LEVEL_RST;
                r_dimm_idx[i] <= 3'd0;
            end
            r_mode     <= lgfm_pkg::MODE_TO_OFF;
            r_mask_idx <= 3'd0;
            r_mask     <= lgfm_pkg::MASK_TABLE_RST[7:0];
        end else if (adv) begin
            r_level    <= n_level;
            r_target   <= n_target;
            r_timer    <= n_timer;
            r_on_level <= n_on_level;
            r_dimm_idx <= n_dimm_idx;
            r_mode     <= n_mode;
            r_mask_idx <= n_mask_idx;
            r_mask     <= n_mask;
        end
    end

    // result snapshot, walked one led per cycle while results are not stalled
    logic [LEDS-1:0][7:0] r_snap_level, r_snap_target;
    logic [LEDS-1:0]      r_snap_changed;
    lgfm_pkg::t_mode      r_snap_mode;
    logic [7:0]           r_snap_mask;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_snap_level   <= n_level;
            r_snap_target  <= n_target;
            r_snap_changed <= n_changed;
            r_snap_mode    <= n_mode;
            r_snap_mask    <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (adv) begin
            r_busy <= 1'b1;
            r_idx  <= '0;
        end else if (out_done) begin
            r_busy <= 1'b0;
            r_idx  <= '0;
        end else if (out_take) begin
            r_idx  <= r_idx + IDX_W'(1);
        end
    end

    assign o_led_index     = lgfm_pkg::LED_IDX_W'(r_idx);
    assign o_level         = r_snap_level[r_idx];
    assign o_target_level  = r_snap_target[r_idx];
    assign o_level_changed = r_snap_changed[r_idx];
    assign o_group_mode    = r_snap_mode;
    assign o_disabled_leds = r_snap_mask;

`ifndef SYNTHESIS
    // a request moving into the snapshot is always reported next
    a_adv_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_busy && r_idx == '0)
        else $error("snapshot not loaded after advance");

    // led walk only moves when a result is taken
    a_idx_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !out_take && !adv |=> $stable(r_idx) && r_busy)
        else $error("led index moved without a result taken");

    // group state only changes when a request advances
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !adv |=> $stable(r_mode) && $stable(r_level) && $stable(r_target))
        else $error("group state changed without a request");

    // dimm request always leaves the group turning on
    a_dimm_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_cmd.op == lgfm_pkg::OP_DIMM |=> r_mode == lgfm_pkg::MODE_TO_ON)
        else $error("dimm request did not start turning on");
`endif

endmodule
